/* rtl/core/psc_pkg.sv */
`default_nettype none

package psc_pkg;

    localparam int ANGLE_W   = 25;
    localparam int VALUE_W   = 24;
    localparam int WORK_FRAC = 24;
    localparam int OUT_FRAC  = 21;

    localparam int XW = 30;
    localparam int YW = 29;
    localparam int KW = 34;

    localparam logic [63:0] K_PI_Q32     = 64'd13493037689;
    localparam logic [63:0] K_TWOPI_Q32  = 64'd26986075421;
    localparam logic [63:0] K_HALFPI_Q32 = 64'd6746518823;

    localparam logic signed [KW-1:0] K_B = 34'sd5468522185;
    localparam logic signed [KW-1:0] K_C = 34'sd1740684682;
    localparam logic signed [KW-1:0] K_P = 34'sd966367642;

    typedef enum logic {
        CMD_SINE   = 1'b0,
        CMD_COSINE = 1'b1
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/psc_angle_if.sv */
`default_nettype none

interface psc_angle_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 cmd;
    logic signed [psc_pkg::ANGLE_W-1:0]   angle;

    modport source (output valid, output cmd, output angle, input ready);
    modport sink (input valid, input cmd, input angle, output ready);
endinterface

`default_nettype wire

/* rtl/core/psc_value_if.sv */
`default_nettype none

interface psc_value_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [psc_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

/* rtl/core/parabolic_sine_cosine.sv */
// channel  modport  beat                      meaning
// req      sink     cmd[0], angle[24:0]      0 sine / 1 cosine, signed Q4.FRAC_BITS rad
// rsp      source   value[23:0]              signed Q2.21, saturated
//
// One beat per cycle sustained while rsp.ready stays high.
// Twelve register stages lie between req and rsp: three reduce the angle, four form the parabola,
// five refine it, the last of them being the saturating output register.
// Reset clears only the stage valid bits; payload registers hold no reset value.
// Each stage advances when it is empty or the stage after it advances, so bubbles fill.
`default_nettype none

module parabolic_sine_cosine #(
    parameter int FRAC_BITS = 20
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    psc_angle_if.sink   req,
    psc_value_if.source rsp
);

    logic                               x_valid;
    logic                               x_ready;
    logic signed [psc_pkg::XW-1:0]      x_data;
    logic                               y_valid;
    logic                               y_ready;
    logic signed [psc_pkg::YW-1:0]      y_data;

    psc_wrap #(
        .FRAC_BITS (FRAC_BITS)
    ) u_wrap (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_cmd    (req.cmd),
        .in_angle  (req.angle),
        .out_valid (x_valid),
        .out_ready (x_ready),
        .out_x     (x_data)
    );

    psc_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (x_valid),
        .in_ready  (x_ready),
        .in_x      (x_data),
        .out_valid (y_valid),
        .out_ready (y_ready),
        .out_y     (y_data)
    );

    psc_refine u_refine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (y_valid),
        .in_ready  (y_ready),
        .in_y      (y_data),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_value (rsp.value)
    );

    a_full_rate: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.ready |-> req.ready)
        else $error("input stalled while the output drains");

endmodule

`default_nettype wire

/* rtl/core/psc_wrap.sv */
`default_nettype none

module psc_wrap #(
    parameter int FRAC_BITS = 20
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 in_cmd,
    input  wire logic signed [psc_pkg::ANGLE_W-1:0]   in_angle,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [psc_pkg::XW-1:0]             out_x
);

    localparam int N  = 3;
    localparam int XW = psc_pkg::XW;
    localparam int AW = ((FRAC_BITS + 5 > psc_pkg::ANGLE_W) ?
                         FRAC_BITS + 5 : psc_pkg::ANGLE_W) + 2;
    localparam int SH = 32 - FRAC_BITS;

    localparam logic [63:0] PI_U     = (psc_pkg::K_PI_Q32 + (64'd1 << (SH - 1))) >> SH;
    localparam logic [63:0] TWOPI_U  = (psc_pkg::K_TWOPI_Q32 + (64'd1 << (SH - 1))) >> SH;
    localparam logic [63:0] HALFPI_U = (psc_pkg::K_HALFPI_Q32 + (64'd1 << (SH - 1))) >> SH;

    localparam logic signed [AW-1:0] PI_A     = AW'(PI_U);
    localparam logic signed [AW-1:0] TWOPI_A  = AW'(TWOPI_U);
    localparam logic signed [AW-1:0] HALFPI_A = AW'(HALFPI_U);
    localparam logic signed [AW-1:0] LIM_A    = AW'(64'd16 << FRAC_BITS);

    logic [N-1:0]            vld_reg;
    logic [N-1:0]            en;

    psc_pkg::cmd_t           cmd0_reg;
    logic signed [AW-1:0]    a_in;
    logic signed [AW-1:0]    a0_next;
    logic signed [AW-1:0]    a0_reg;
    logic signed [AW-1:0]    sum_s;
    logic signed [AW-1:0]    sum_t;
    logic signed [AW-1:0]    a1_next;
    logic signed [AW-1:0]    a1_reg;
    logic signed [AW-1:0]    ac;
    logic signed [XW-1:0]    x_scaled;
    logic signed [XW-1:0]    x2_reg;

    always_comb
    begin
        en[N-1] = !vld_reg[N-1] || out_ready;
        for (int i = N - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[N-1];
    assign out_x     = x2_reg;

    // reduce once by a full turn
    always_comb
    begin
        a_in = AW'(in_angle);
        priority if (a_in < -PI_A)
        begin
            a0_next = a_in + TWOPI_A;
        end
        else if (a_in > PI_A)
        begin
            a0_next = a_in - TWOPI_A;
        end
        else
        begin
            a0_next = a_in;
        end
    end

    // shift cosine by a quarter turn
    always_comb
    begin
        sum_s = a0_reg + HALFPI_A;
        sum_t = sum_s - TWOPI_A;
        if (cmd0_reg == psc_pkg::CMD_COSINE)
        begin
            a1_next = (sum_s > PI_A) ? sum_t : sum_s;
        end
        else
        begin
            a1_next = a0_reg;
        end
    end

    always_comb
    begin
        priority if (a1_reg > LIM_A)
        begin
            ac = LIM_A;
        end
        else if (a1_reg < -LIM_A)
        begin
            ac = -LIM_A;
        end
        else
        begin
            ac = a1_reg;
        end
    end

    if (FRAC_BITS <= psc_pkg::WORK_FRAC)
    begin : g_up
        assign x_scaled = XW'(ac) <<< (psc_pkg::WORK_FRAC - FRAC_BITS);
    end
    else
    begin : g_dn
        localparam int DS = FRAC_BITS - psc_pkg::WORK_FRAC;
        localparam logic signed [AW-1:0] RND = AW'(64'd1 << (DS - 1));
        assign x_scaled = XW'((ac + RND) >>> DS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < N; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a0_reg   <= a0_next;
            cmd0_reg <= psc_pkg::cmd_t'(in_cmd);
        end
        if (en[1])
        begin
            a1_reg <= a1_next;
        end
        if (en[2])
        begin
            x2_reg <= x_scaled;
        end
    end

    a_stage0_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && !en[1] |=> vld_reg[0] && $stable(a0_reg) && $stable(cmd0_reg))
        else $error("reduced angle lost while stalled");

endmodule

`default_nettype wire

/* rtl/core/psc_poly.sv */
`default_nettype none

module psc_poly (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [psc_pkg::XW-1:0] in_x,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [psc_pkg::YW-1:0]      out_y
);

    localparam int N   = 4;
    localparam int XW  = psc_pkg::XW;
    localparam int YW  = psc_pkg::YW;
    localparam int PAW = 2 * XW - 2;
    localparam int SQW = 34;
    localparam int EW  = 34;

    localparam logic signed [PAW-1:0] RND_PA = PAW'(64'd1 << (psc_pkg::WORK_FRAC - 1));
    localparam logic signed [63:0]    RND32  = 64'sd1 <<< 31;
    localparam logic signed [EW-1:0]  LIM_Y  = EW'(64'd8 << psc_pkg::WORK_FRAC);

    logic [N-1:0]             vld_reg;
    logic [N-1:0]             en;

    logic signed [XW-1:0]     ax;
    logic signed [PAW-1:0]    pa0_next;
    logic signed [PAW-1:0]    pa0_reg;
    logic signed [63:0]       pb0_next;
    logic signed [63:0]       pb0_reg;
    logic signed [SQW-1:0]    sq1_next;
    logic signed [SQW-1:0]    sq1_reg;
    logic signed [31:0]       bx1_next;
    logic signed [31:0]       bx1_reg;
    logic signed [63:0]       pc2_next;
    logic signed [63:0]       pc2_reg;
    logic signed [31:0]       bx2_reg;
    logic signed [31:0]       cterm;
    logic signed [EW-1:0]     y_wide;
    logic signed [YW-1:0]     y3_next;
    logic signed [YW-1:0]     y3_reg;

    always_comb
    begin
        en[N-1] = !vld_reg[N-1] || out_ready;
        for (int i = N - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[N-1];
    assign out_y     = y3_reg;

    always_comb
    begin
        ax       = in_x[XW-1] ? -in_x : in_x;
        pa0_next = PAW'(in_x) * PAW'(ax);
        pb0_next = 64'(in_x) * 64'(psc_pkg::K_B);
        sq1_next = SQW'((pa0_reg + RND_PA) >>> psc_pkg::WORK_FRAC);
        bx1_next = 32'((pb0_reg + RND32) >>> 32);
        pc2_next = 64'(sq1_reg) * 64'(psc_pkg::K_C);
        cterm    = 32'((pc2_reg + RND32) >>> 32);
        y_wide   = EW'(bx2_reg) - EW'(cterm);
    end

    // clamp the first estimate
    always_comb
    begin
        priority if (y_wide > LIM_Y)
        begin
            y3_next = YW'(LIM_Y);
        end
        else if (y_wide < -LIM_Y)
        begin
            y3_next = YW'(-LIM_Y);
        end
        else
        begin
            y3_next = YW'(y_wide);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < N; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pa0_reg <= pa0_next;
            pb0_reg <= pb0_next;
        end
        if (en[1])
        begin
            sq1_reg <= sq1_next;
            bx1_reg <= bx1_next;
        end
        if (en[2])
        begin
            pc2_reg <= pc2_next;
            bx2_reg <= bx1_reg;
        end
        if (en[3])
        begin
            y3_reg <= y3_next;
        end
    end

    a_drain_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("parabola stages stall while the next stage takes data");

endmodule

`default_nettype wire

/* rtl/core/psc_refine.sv */
`default_nettype none

module psc_refine (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [psc_pkg::YW-1:0] in_y,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [psc_pkg::VALUE_W-1:0] out_value
);

    localparam int N   = 5;
    localparam int YW  = psc_pkg::YW;
    localparam int VW  = psc_pkg::VALUE_W;
    localparam int PYW = 2 * YW - 2;
    localparam int DW  = 32;
    localparam int RW  = 31;
    localparam int OS  = psc_pkg::WORK_FRAC - psc_pkg::OUT_FRAC;

    localparam logic signed [PYW-1:0] RND_PY = PYW'(64'd1 << (psc_pkg::WORK_FRAC - 1));
    localparam logic signed [63:0]    RND32  = 64'sd1 <<< 31;
    localparam logic signed [RW-1:0]  RND_O  = RW'(64'd1 << (OS - 1));
    localparam logic signed [RW-1:0]  VMAX   = RW'((64'd1 << (VW - 1)) - 64'd1);
    localparam logic signed [RW-1:0]  VMIN   = -RW'(64'd1 << (VW - 1));

    logic [N-1:0]             vld_reg;
    logic [N-1:0]             en;

    logic signed [YW-1:0]     ay;
    logic signed [PYW-1:0]    py0_next;
    logic signed [PYW-1:0]    py0_reg;
    logic signed [YW-1:0]     y0_reg;
    logic signed [DW-1:0]     yy;
    logic signed [DW-1:0]     d1_next;
    logic signed [DW-1:0]     d1_reg;
    logic signed [YW-1:0]     y1_reg;
    logic signed [63:0]       pp2_next;
    logic signed [63:0]       pp2_reg;
    logic signed [YW-1:0]     y2_reg;
    logic signed [RW-1:0]     r3_next;
    logic signed [RW-1:0]     r3_reg;
    logic signed [RW-1:0]     r_out;
    logic signed [VW-1:0]     value4_next;
    logic signed [VW-1:0]     value4_reg;

    always_comb
    begin
        en[N-1] = !vld_reg[N-1] || out_ready;
        for (int i = N - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[N-1];
    assign out_value = value4_reg;

    always_comb
    begin
        ay       = in_y[YW-1] ? -in_y : in_y;
        py0_next = PYW'(in_y) * PYW'(ay);
        yy       = DW'((py0_reg + RND_PY) >>> psc_pkg::WORK_FRAC);
        d1_next  = yy - DW'(y0_reg);
        pp2_next = 64'(d1_reg) * 64'(psc_pkg::K_P);
        r3_next  = RW'((pp2_reg + RND32) >>> 32) + RW'(y2_reg);
        r_out    = (r3_reg + RND_O) >>> OS;
    end

    // saturate to the output range
    always_comb
    begin
        priority if (r_out > VMAX)
        begin
            value4_next = VW'(VMAX);
        end
        else if (r_out < VMIN)
        begin
            value4_next = VW'(VMIN);
        end
        else
        begin
            value4_next = VW'(r_out);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < N; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            py0_reg <= py0_next;
            y0_reg  <= in_y;
        end
        if (en[1])
        begin
            d1_reg <= d1_next;
            y1_reg <= y0_reg;
        end
        if (en[2])
        begin
            pp2_reg <= pp2_next;
            y2_reg  <= y1_reg;
        end
        if (en[3])
        begin
            r3_reg <= r3_next;
        end
        if (en[4])
        begin
            value4_reg <= value4_next;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[N-1] && !out_ready |=> vld_reg[N-1] && $stable(value4_reg))
        else $error("result beat dropped or changed while stalled");

    a_refine_advance: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] && en[3] |=> vld_reg[3])
        else $error("refinement product lost between stages");

endmodule

`default_nettype wire
